// ===== src/fbcs_pkg.sv =====
// Shared types and constants for the frame band change scorer.
package fbcs_pkg;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_MULT  = 32'd16777619;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_BAND,
        ST_COV,
        ST_CHN,
        ST_MIX,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_reg_idx;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [39:0] num;
        logic [39:0] den;
    } t_div_req;

    // Status back from the shared divider.
    typedef struct packed {
        logic        done;
        logic [39:0] quo;
    } t_div_rsp;

    function automatic logic [3:0] ink_of(input logic [7:0] b);
        logic [3:0] ones;
        ones = 4'd0;
        for (int i = 0; i < 8; i++) begin
            ones = ones + {3'd0, b[i]};
        end
        return 4'd8 - ones;
    endfunction

endpackage

// ===== src/fbcs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module fbcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbcs_pkg::t_div_req i_req,
    output fbcs_pkg::t_div_rsp o_rsp
);
    import fbcs_pkg::*;

    logic [39:0] r_quo, n_quo;
    logic [39:0] r_rem, n_rem;
    logic [39:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [40:0] trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = '0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 6'd40;
            n_busy = 1'b1;
        end else if (r_busy) begin
            trial = {r_rem, r_quo[39]} - {1'b0, r_den};
            if (!trial[40]) begin
                n_rem = trial[39:0];
                n_quo = {r_quo[38:0], 1'b1};
            end else begin
                n_rem = {r_rem[38:0], r_quo[39]};
                n_quo = {r_quo[38:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_no_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider busy and done");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0) else $error("divider count underflow");
`endif
endmodule

// ===== src/fbcs_mul.sv =====
// Shared 32x32 multiplier with registered product.
module fbcs_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

// ===== src/frame_band_change_scorer_core.sv =====
// Top level of the frame band change scorer: band hashing, compare and scoring.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | in        | i_valid / o_stall         | i_mode, i_pixel_byte
//  out     | out       | o_valid / i_stall         | o_score, o_changed_bands, ...
//  cfg     | in        | APB psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// A frame byte is hashed by a multiply, then an update; a byte that closes a band adds a
// step for the store compare and write. The last byte of a comparable frame runs two
// 40-step passes of the shared divider before its beat is raised; a frame that cannot be
// compared raises its beat without the divider. The input stalls while an item is at
// work or a beat waits on the output. Reset is synchronous and active low; the band
// store has no reset, and its contents are used only after a full frame wrote them.
module frame_band_change_scorer_core #(
    parameter int ROWS_PER_BAND   = 8,
    parameter int BAND_LIMIT      = 128,
    parameter int SCORE_TOP       = 1000,
    parameter int ROW_BYTES_LIMIT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_score,
    output logic [7:0]  o_changed_bands,
    output logic [7:0]  o_first_changed_band,
    output logic [6:0]  o_last_changed_band,
    output logic [7:0]  o_total_bands,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fbcs_pkg::*;

    localparam int BI_W = $clog2(BAND_LIMIT) > 0 ? $clog2(BAND_LIMIT) : 1;

    t_state r_state, n_state;

    logic [7:0]  r_width;
    logic [10:0] r_height;

    // band store: hash and ink per band
    logic [31:0] mem_hash [BAND_LIMIT];
    logic [13:0] mem_ink  [BAND_LIMIT];
    logic [31:0] r_old_hash;
    logic [13:0] r_old_ink;

    logic        r_primed;
    logic [7:0]  r_old_total;
    logic [31:0] r_hash;
    logic [13:0] r_ink;
    logic [17:0] r_pos;
    logic [7:0]  r_band;
    logic [7:0]  r_changed;
    logic [20:0] r_churn;
    logic [7:0]  r_first;
    logic [6:0]  r_last;
    logic [17:0] r_band_end;
    logic [7:0]  r_byte;
    logic [9:0]  r_cov;
    logic [9:0]  r_chn;

    logic        r_oval;
    logic [9:0]  r_score;
    logic [7:0]  r_ochg, r_ofirst, r_ototal;
    logic [6:0]  r_olast;

    // effective sizes
    logic [7:0]  w_eff;
    logic [10:0] h_eff;
    logic [7:0]  bands;
    logic [16:0] band_bytes;
    logic [17:0] frame_bytes;
    logic        comparable;

    always_comb begin
        w_eff = (r_width == 8'd0) ? 8'd1 : r_width;
        if ({3'd0, w_eff} > 11'(ROW_BYTES_LIMIT)) w_eff = 8'(ROW_BYTES_LIMIT);
        h_eff = (r_height == 11'd0) ? 11'd1 : r_height;
        if (32'(h_eff) > BAND_LIMIT * ROWS_PER_BAND) h_eff = 11'(BAND_LIMIT * ROWS_PER_BAND);
        bands       = 8'((32'(h_eff) + ROWS_PER_BAND - 1) / ROWS_PER_BAND);
        band_bytes  = 17'(32'(w_eff) * ROWS_PER_BAND);
        frame_bytes = 18'({10'd0, w_eff} * {7'd0, h_eff});
        comparable  = r_primed && (r_old_total == bands);
    end

    // band end for the current band, clamped to frame end
    logic [17:0] band_end_calc;
    always_comb begin
        band_end_calc = 18'((32'(r_band) + 1) * 32'(band_bytes));
        if (32'(r_band + 8'd1) * 32'(band_bytes) > 32'(frame_bytes)) band_end_calc = frame_bytes;
    end

    // shared multiplier: hash step, then score scaling
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    fbcs_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    t_div_req div_req;
    t_div_rsp div_rsp;
    fbcs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic cfg_wr, accept, band_done, is_changed;
    logic [13:0] ink_new, ink_diff;
    logic [31:0] hash_new;
    logic [17:0] pos_new;
    logic [9:0]  mix;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_oval;

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {24'd0, r_width};
            default: prdata = {21'd0, r_height};
        endcase
    end

    assign hash_new  = mul_p[31:0];
    assign pos_new   = r_pos + 18'd1;
    assign ink_new   = r_ink + {10'd0, ink_of(r_byte)};
    assign band_done = (pos_new >= r_band_end) && (32'(r_band) < BAND_LIMIT);
    assign is_changed = !(comparable && (r_old_hash == r_hash));
    assign ink_diff  = (r_old_ink > r_ink) ? r_old_ink - r_ink : r_ink - r_old_ink;
    // divide the weighted sum (at most 10000) by ten: 6554 / 2^16 is exact there
    assign mix       = 10'(((32'(r_cov) * 3 + 32'(r_chn) * 7) * 6554) >> 16);

    always_comb begin
        mul_a = r_hash ^ {24'd0, r_byte};
        mul_b = HASH_MULT;
        div_req = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // start the hash step on the byte being accepted
                mul_a = r_hash ^ {24'd0, i_pixel_byte};
                if (accept && !i_mode) n_state = ST_HASH;
            end
            ST_HASH: begin
                n_state = ST_IDLE;
                if (band_done) n_state = ST_BAND;
                else if (pos_new >= frame_bytes) n_state = ST_COV;
            end
            ST_BAND: begin
                n_state = (r_pos >= frame_bytes) ? ST_COV : ST_IDLE;
                // scale the count as it stands after this band
                mul_a = {24'd0, r_changed + {7'd0, is_changed}};
                mul_b = 32'(SCORE_TOP);
            end
            ST_COV: begin
                mul_a = {24'd0, r_changed};
                mul_b = 32'(SCORE_TOP);
                if (!comparable) begin
                    n_state = ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_p[39:0];
                    div_req.den   = {32'd0, bands};
                    n_state = ST_CHN;
                end
            end
            ST_CHN: begin
                mul_a = {11'd0, r_churn};
                mul_b = 32'(SCORE_TOP);
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_p[39:0];
                    div_req.den   = {19'd0, frame_bytes, 3'd0};
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (div_rsp.done) n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HASH && band_done) begin
            r_old_hash <= mem_hash[r_band[BI_W-1:0]];
            r_old_ink  <= mem_ink[r_band[BI_W-1:0]];
        end
        if (r_state == ST_BAND) begin
            mem_hash[r_band[BI_W-1:0]] <= r_hash;
            mem_ink[r_band[BI_W-1:0]]  <= r_ink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_byte <= i_pixel_byte;
        if (r_state == ST_IDLE) r_band_end <= band_end_calc;
        if (r_state == ST_CHN && div_rsp.done) r_cov <= div_rsp.quo[9:0];
        if (r_state == ST_MIX && div_rsp.done)
            r_chn <= (div_rsp.quo > 40'(SCORE_TOP)) ? 10'(SCORE_TOP) : div_rsp.quo[9:0];
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_width <= 8'd100;
            r_height <= 11'd480;
            r_primed <= 1'b0;
            r_old_total <= 8'd0;
            r_hash <= HASH_BASIS;
            r_ink <= 14'd0;
            r_pos <= 18'd0;
            r_band <= 8'd0;
            r_changed <= 8'd0;
            r_churn <= 21'd0;
            r_first <= 8'd0;
            r_last <= 7'd0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_oval && !i_stall) r_oval <= 1'b0;
            // restart the frame on any register write or forget beat
            if (cfg_wr && (paddr[2] == REG_WIDTH[0] || paddr[2] == REG_HEIGHT[0])) begin
                if (paddr[2]) r_height <= pwdata[10:0];
                else          r_width  <= pwdata[7:0];
                r_primed <= 1'b0;
                r_hash <= HASH_BASIS; r_ink <= '0; r_pos <= '0; r_band <= '0;
                r_changed <= '0; r_churn <= '0; r_first <= '0; r_last <= '0;
            end
            if (accept && i_mode) begin
                r_primed <= 1'b0;
                r_old_total <= 8'd0;
                r_hash <= HASH_BASIS; r_ink <= '0; r_pos <= '0; r_band <= '0;
                r_changed <= '0; r_churn <= '0; r_first <= '0; r_last <= '0;
            end
            if (r_state == ST_HASH) begin
                r_hash <= hash_new;
                r_ink  <= ink_new;
                r_pos  <= pos_new;
            end
            if (r_state == ST_BAND) begin
                if (is_changed) begin
                    if (r_changed == 8'd0) r_first <= r_band;
                    r_changed <= r_changed + 8'd1;
                    r_last <= r_band[6:0];
                    r_churn <= r_churn + {7'd0, comparable ? ink_diff : r_ink};
                end
                r_hash <= HASH_BASIS;
                r_ink  <= 14'd0;
                r_band <= r_band + 8'd1;
            end
            if (r_state == ST_OUT) begin
                r_oval   <= 1'b1;
                r_score  <= comparable ? ((32'(mix) > SCORE_TOP) ? 10'(SCORE_TOP) : mix)
                                       : 10'(SCORE_TOP);
                r_ochg   <= r_changed;
                r_ofirst <= (r_changed != 8'd0) ? r_first : bands;
                r_olast  <= (r_changed != 8'd0) ? r_last : 7'd0;
                r_ototal <= bands;
                r_old_total <= bands;
                r_primed <= 1'b1;
                r_hash <= HASH_BASIS; r_ink <= '0; r_pos <= '0; r_band <= '0;
                r_changed <= '0; r_churn <= '0; r_first <= '0; r_last <= '0;
            end
        end
    end

    assign o_valid              = r_oval;
    assign o_score              = r_score;
    assign o_changed_bands      = r_ochg;
    assign o_first_changed_band = r_ofirst;
    assign o_last_changed_band  = r_olast;
    assign o_total_bands        = r_ototal;

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input taken while busy");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_OUT)) else $error("stray result");
    a_primed_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_primed) else $error("not primed after frame");
`endif
endmodule
